>>> hdl/artl_pkg.sv
// ----------------------------------------------------------------------------
// artl_pkg
// Shared types and codes for the audio reassembly block with talker lock.
// ----------------------------------------------------------------------------
package artl_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SELECT_MODE  = 2'd0;
    localparam logic [1:0] CFG_OWN_GROUP    = 2'd1;
    localparam logic [1:0] CFG_TARGET_GROUP = 2'd2;
    localparam logic [1:0] CFG_TARGET_POINT = 2'd3;

    // select_mode codes; the unused code behaves as point mode
    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_GROUP = 2'd2;

    // message types
    localparam logic [1:0] MSG_TO_HOST = 2'd0;
    localparam logic [1:0] MSG_TO_ALL  = 2'd1;

    localparam logic [3:0] BYTES_PER_WORD = 4'd8;

    typedef struct packed {
        logic [1:0] select_mode;
        logic [6:0] own_group;
        logic [6:0] target_group;
        logic [6:0] target_point;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  src_group;
        logic [6:0]  src_point;
        logic [1:0]  msg_type;
        logic [3:0]  seg_index;
        logic [3:0]  seg_count;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_item;

    // store request from the front to the back
    typedef struct packed {
        logic        is_final;
        logic [3:0]  word_idx;
        logic [7:0]  byte_en;
        logic [63:0] data;
        logic [7:0]  length;
        logic [3:0]  last_idx;
        logic [6:0]  group;
        logic [6:0]  point;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_bk_state;

endpackage

>>> hdl/audio_reassembly_talker_lock.sv
// ----------------------------------------------------------------------------
// audio_reassembly_talker_lock
// Reassembles segmented audio frames from decoded bus frames under a
// talker-lock policy and streams each finished frame out in 8-byte words.
// ----------------------------------------------------------------------------
// Input side is a queue: present a decoded bus frame and raise push; it is
// taken at an edge where full is low. Results come out of a queue: while
// empty is low the oldest word sits on the o_ ports; pop takes it.
// Configuration writes go through i_cfg_valid / o_cfg_ready (always ready),
// index 0 select_mode, 1 own_group, 2 target_group, 3 target_point.
// The front applies the lock policy in the accept cycle and queues a store
// request (two-entry queue). The back writes a segment; after a final
// segment it emits each word of the frame by a store read and then a load
// of the result register, and takes no new request until the last word
// is loaded. Non-final segments sustain one per cycle while the back is free.
// Reset restores register defaults, drops the lock and marks every store
// word unwritten, so the store reads as zero at once with no clearing pass.
// When the receiver stalls, the result register holds, the back waits, the
// request queue fills and full rises.
// ----------------------------------------------------------------------------
module audio_reassembly_talker_lock import artl_pkg::*; #(
    parameter int FRAME_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [6:0]  i_src_group,
    input  logic [6:0]  i_src_point,
    input  logic [1:0]  i_msg_type,
    input  logic [3:0]  i_seg_index,
    input  logic [3:0]  i_seg_count,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_payload,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_frame_word,
    output logic [3:0]  o_word_offset,
    output logic [7:0]  o_frame_length,
    output logic [6:0]  o_talker_group,
    output logic [6:0]  o_talker_point,
    output logic        o_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    t_cfg  r_cfg;
    t_item item;
    t_cmd  cmd;
    t_cmd  q_head;
    logic  accept;
    logic  cmd_vld;
    logic  q_empty;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_mode  <= MODE_ALL;
            r_cfg.own_group    <= 7'd1;
            r_cfg.target_group <= 7'd0;
            r_cfg.target_point <= 7'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SELECT_MODE:  r_cfg.select_mode  <= i_cfg_data[1:0];
                CFG_OWN_GROUP:    r_cfg.own_group    <= i_cfg_data;
                CFG_TARGET_GROUP: r_cfg.target_group <= i_cfg_data;
                CFG_TARGET_POINT: r_cfg.target_point <= i_cfg_data;
                default:          r_cfg.select_mode  <= r_cfg.select_mode;
            endcase
        end
    end

    assign accept = push && !full;

    assign item.src_group  = i_src_group;
    assign item.src_point  = i_src_point;
    assign item.msg_type   = i_msg_type;
    assign item.seg_index  = i_seg_index;
    assign item.seg_count  = i_seg_count;
    assign item.byte_count = i_byte_count;
    assign item.payload    = i_payload;

    artl_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_item    (item),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd)
    );

    artl_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_vld),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    artl_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_frame_word   (o_frame_word),
        .o_word_offset  (o_word_offset),
        .o_frame_length (o_frame_length),
        .o_talker_group (o_talker_group),
        .o_talker_point (o_talker_point),
        .o_last_word    (o_last_word)
    );

    // the last word of a frame sits at the offset its length implies
    a_last_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_word) |->
            ((o_frame_length == 8'd0 && o_word_offset == 4'd0) ||
             (o_frame_length != 8'd0 &&
              o_word_offset == 4'((o_frame_length - 8'd1) >> 3))))
        else $error("last word offset does not match frame length");

    // a new frame always starts at word zero
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_word) |=> (empty || o_word_offset == 4'd0))
        else $error("frame does not start at word zero");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({1'b0, o_frame_length} <= 9'(FRAME_BYTES)))
        else $error("frame length exceeds store size");

endmodule

>>> hdl/artl_front.sv
// ----------------------------------------------------------------------------
// artl_front
// Talker-lock policy and classification of received bus frames into store
// requests.
// ----------------------------------------------------------------------------
module artl_front import artl_pkg::*; #(
    parameter int FRAME_BYTES = 128
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_accept,
    input  t_item i_item,
    output logic  o_cmd_vld,
    output t_cmd  o_cmd
);

    localparam logic [8:0] FB9 = 9'(FRAME_BYTES);

    logic       r_lock_vld, n_lock_vld;
    logic [6:0] r_lock_group, n_lock_group;
    logic [6:0] r_lock_point, n_lock_point;

    logic       pass;
    logic       known_type;
    logic       take;
    logic       live;
    logic       is_final;
    logic [3:0] word_idx;
    logic [3:0] bc_sat;
    logic [3:0] nbytes;
    logic [8:0] pos;
    logic [7:0] len_raw;
    logic [7:0] len_sat;

    always_comb begin
        unique case (i_cfg.select_mode)
            MODE_ALL:   pass = 1'b1;
            MODE_GROUP: pass = (i_item.src_group == i_cfg.target_group);
            default:    pass = (i_item.src_group == i_cfg.target_group) &&
                               (i_item.src_point == i_cfg.target_point);
        endcase

        known_type = (i_item.msg_type == MSG_TO_HOST) || (i_item.msg_type == MSG_TO_ALL);
        take = !r_lock_vld ||
               (r_lock_group == i_item.src_group && r_lock_point == i_item.src_point) ||
               (r_lock_group != i_cfg.own_group && i_item.src_group == i_cfg.own_group);
        live = i_accept && (i_item.src_group != 7'd0) && pass && known_type;

        n_lock_vld   = r_lock_vld;
        n_lock_group = r_lock_group;
        n_lock_point = r_lock_point;
        if (live && take) begin
            n_lock_vld   = 1'b1;
            n_lock_group = i_item.src_group;
            n_lock_point = i_item.src_point;
        end

        // a to-host frame passes even when it loses the lock
        o_cmd_vld = live && (i_item.msg_type == MSG_TO_HOST || take) &&
                    (i_item.seg_index != 4'd0);

        is_final = (i_item.seg_index == i_item.seg_count);
        word_idx = i_item.seg_index - 4'd1;
        bc_sat   = (i_item.byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : i_item.byte_count;
        nbytes   = is_final ? bc_sat : BYTES_PER_WORD;

        o_cmd.is_final = is_final;
        o_cmd.word_idx = word_idx;
        o_cmd.data     = i_item.payload;
        o_cmd.group    = i_item.src_group;
        o_cmd.point    = i_item.src_point;
        for (int i = 0; i < 8; i++) begin
            pos = 9'({word_idx, 3'b000}) + 9'(i);
            // drop bytes that fall past the store
            o_cmd.byte_en[i] = (4'(i) < nbytes) && (pos < FB9);
        end

        len_raw = 8'({word_idx, 3'b000}) + 8'(bc_sat);
        len_sat = ({1'b0, len_raw} > FB9) ? 8'(FRAME_BYTES) : len_raw;
        o_cmd.length   = len_sat;
        o_cmd.last_idx = (len_sat == 8'd0) ? 4'd0 : 4'((len_sat - 8'd1) >> 3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_vld   <= 1'b0;
            r_lock_group <= 7'd0;
            r_lock_point <= 7'd0;
        end else begin
            r_lock_vld   <= n_lock_vld;
            r_lock_group <= n_lock_group;
            r_lock_point <= n_lock_point;
        end
    end

endmodule

>>> hdl/artl_cmdq.sv
// ----------------------------------------------------------------------------
// artl_cmdq
// Two-entry queue of store requests between the front and the back.
// ----------------------------------------------------------------------------
module artl_cmdq import artl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_entry [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_entry[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> hdl/artl_back.sv
// ----------------------------------------------------------------------------
// artl_back
// Frame store and readout: writes segment bytes, then streams a finished
// frame out word by word through the result register.
// ----------------------------------------------------------------------------
module artl_back import artl_pkg::*; #(
    parameter int FRAME_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_head,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [63:0] o_frame_word,
    output logic [3:0]  o_word_offset,
    output logic [7:0]  o_frame_length,
    output logic [6:0]  o_talker_group,
    output logic [6:0]  o_talker_point,
    output logic        o_last_word
);

    localparam int STORE_WORDS = (FRAME_BYTES + 7) / 8;
    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    logic [63:0]            r_store [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_wvalid;

    t_bk_state   r_state, n_state;
    logic [3:0]  r_w, n_w;
    logic [7:0]  r_len;
    logic [3:0]  r_last_idx;
    logic [6:0]  r_group;
    logic [6:0]  r_point;
    logic [63:0] r_rd_data;
    logic        r_rd_ok;

    logic        r_out_vld, n_out_vld;
    logic [63:0] r_out_word;
    logic [3:0]  r_out_off;
    logic [7:0]  r_out_len;
    logic [6:0]  r_out_group;
    logic [6:0]  r_out_point;
    logic        r_out_last;

    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    mem_we;
    logic [63:0]   mem_wdata;
    logic          take_cmd;
    logic          out_free;
    logic          out_load;
    logic [7:0]    bpos;
    logic [63:0]   masked;

    assign waddr = AW'(i_q_head.word_idx);
    assign raddr = AW'(r_w);

    always_comb begin
        take_cmd = (r_state == ST_IDLE) && !i_q_empty;
        o_q_pop  = take_cmd;

        // a word never written reads as zero: fill its other bytes with zero
        mem_we    = 8'd0;
        mem_wdata = i_q_head.data;
        if (take_cmd && (|i_q_head.byte_en)) begin
            if (r_wvalid[waddr]) begin
                mem_we = i_q_head.byte_en;
            end else begin
                mem_we = 8'hFF;
                for (int b = 0; b < 8; b++) begin
                    if (!i_q_head.byte_en[b]) begin
                        mem_wdata[b*8 +: 8] = 8'd0;
                    end
                end
            end
        end

        out_free = !r_out_vld || i_pop;
        out_load = (r_state == ST_EMIT) && out_free;

        masked = 64'd0;
        for (int i = 0; i < 8; i++) begin
            bpos = 8'({r_w, 3'b000}) + 8'(i);
            if (r_rd_ok && (bpos < r_len)) begin
                masked[i*8 +: 8] = r_rd_data[i*8 +: 8];
            end
        end

        n_state = r_state;
        n_w     = r_w;
        unique case (r_state)
            ST_IDLE: begin
                if (take_cmd && i_q_head.is_final) begin
                    n_state = ST_READ;
                    n_w     = 4'd0;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (r_w == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_w     = r_w + 4'd1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_vld = r_out_vld;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 8; b++) begin
            if (mem_we[b]) begin
                r_store[waddr][b*8 +: 8] <= mem_wdata[b*8 +: 8];
            end
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_store[raddr];
            r_rd_ok   <= r_wvalid[raddr];
        end
        if (take_cmd && i_q_head.is_final) begin
            r_len      <= i_q_head.length;
            r_last_idx <= i_q_head.last_idx;
            r_group    <= i_q_head.group;
            r_point    <= i_q_head.point;
        end
        if (out_load) begin
            r_out_word  <= masked;
            r_out_off   <= r_w;
            r_out_len   <= r_len;
            r_out_group <= r_group;
            r_out_point <= r_point;
            r_out_last  <= (r_w == r_last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_w       <= 4'd0;
            r_out_vld <= 1'b0;
            r_wvalid  <= '0;
        end else begin
            r_state   <= n_state;
            r_w       <= n_w;
            r_out_vld <= n_out_vld;
            if (|mem_we) begin
                r_wvalid[waddr] <= 1'b1;
            end
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_frame_word   = r_out_word;
    assign o_word_offset  = r_out_off;
    assign o_frame_length = r_out_len;
    assign o_talker_group = r_out_group;
    assign o_talker_point = r_out_point;
    assign o_last_word    = r_out_last;

endmodule
